FILE: sv/mwo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mwo_pkg;

  // item kinds
  localparam logic [1:0] KIND_WHEEL = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SEP  = 3'd0;
  localparam logic [2:0] REG_BASE = 3'd1;
  localparam logic [2:0] REG_RLF  = 3'd2;
  localparam logic [2:0] REG_RLR  = 3'd3;
  localparam logic [2:0] REG_RRF  = 3'd4;
  localparam logic [2:0] REG_RRR  = 3'd5;
  localparam logic [2:0] REG_WLEN = 3'd6;

  localparam logic [5:0]  WLEN_RESET = 6'd10;
  localparam logic [31:0] MIN_DT     = 32'd100;
  localparam logic [31:0] US_PER_S   = 32'd1000000;
  localparam logic [6:0]  DIV_STEPS  = 7'd64;

  // ceil(2^83 / 1e6): the product with any magnitude below 2^63, shifted
  // right by 83, is that magnitude over 1e6 rounded down
  localparam logic [63:0] US_RECIP   = 64'd9671406556917033398;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic        [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mwo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mwo_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/mwo_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mwo_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mwo_pkg::div_req_t req,
  output mwo_pkg::div_rsp_t      rsp
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] num_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        take;

  // one restoring step per cycle
  assign rem_sh  = {rem_r, num_r[63]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign take    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= mwo_pkg::DIV_STEPS;
        neg_r  <= req.num[63];
        num_r  <= req.num[63] ? 64'(-req.num) : 64'(req.num);
        den_r  <= req.den;
        rem_r  <= 32'd0;
      end else if (busy_r) begin
        rem_r <= take ? rem_sub[31:0] : rem_sh[31:0];
        num_r <= {num_r[62:0], take};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restore the sign, quotient rounds toward zero
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -$signed(num_r) : $signed(num_r);

endmodule
`default_nettype wire

FILE: sv/mecanum_wheel_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Each item is taken in the idle state and handled by a sequencer: a wheel item that
// refreshes the speeds makes seven passes of the shared divider, six with zero geometry;
// a wheel item with a short interval makes one pass, none with zero geometry; an open-loop
// item uses no divider; a start or unused kind goes straight to the result beat. One item at
// a time: the next beat is taken in the cycle after the result is loaded; a stalled result holds.
// Reset (synchronous, rst_n low) clears pose, travel, time, window sums and
// counts and speeds; window memory contents are not cleared.
module mecanum_wheel_odometry #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic signed [31:0] in_angle_left_front,
  input  wire logic signed [31:0] in_angle_left_rear,
  input  wire logic signed [31:0] in_angle_right_front,
  input  wire logic signed [31:0] in_angle_right_rear,
  input  wire logic signed [31:0] in_command_vx,
  input  wire logic signed [31:0] in_command_vy,
  input  wire logic signed [31:0] in_command_w,
  input  wire logic [31:0]        in_time_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pose_x,
  output logic signed [31:0]      out_pose_y,
  output logic signed [31:0]      out_pose_heading,
  output logic signed [31:0]      out_speed_x,
  output logic signed [31:0]      out_speed_y,
  output logic signed [31:0]      out_speed_w,
  output logic                    out_updated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);

  localparam int LW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUMW = 33 + SW;

  typedef enum logic [4:0] {
    S_IDLE, S_TM, S_TW, S_TU, S_WS, S_WD, S_POSE,
    S_VM, S_VW, S_VD, S_VQ, S_RD, S_RW, S_MD, S_MQ,
    S_OM, S_OW, S_OD, S_OR, S_ORW, S_ORA, S_OQ, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] idx_r;

  // configuration
  logic [16:0] sep_r, base_r;
  logic [15:0] rad_r [4];
  logic [5:0]  wlen_r;

  // block state
  logic signed [31:0]   pose_r [3];
  logic signed [31:0]   trav_r [4];
  logic [31:0]          last_r;
  logic signed [SUMW-1:0] sum_r [3];
  logic [SW-1:0]        slot_r;
  logic [LW-1:0]        fill_r;
  logic signed [31:0]   spd_r [3];

  // item and work registers
  logic signed [31:0] ang_r [4];
  logic signed [31:0] cmd_r [3];
  logic [31:0]        now_r;
  logic signed [32:0] d_r [4];
  logic signed [31:0] disp_r [3];
  logic signed [31:0] v_r [3];
  logic               upd_r;

  // shared multiplier
  logic signed [32:0] mul_a_r, mul_b_r;
  logic signed [65:0] mul_p_r;

  // open-loop division by 1e6: magnitude, sign, accumulator, partial index
  logic [63:0]  rx_r;
  logic         rneg_r;
  logic [127:0] racc_r;
  logic [1:0]   pp_r;
  logic [6:0]   pp_sh;
  logic [127:0] pp_ext;
  logic [44:0]  rq;
  logic signed [63:0] rquo;

  // output register
  logic               out_valid_r;
  logic signed [31:0] o_pose_r [3];
  logic signed [31:0] o_spd_r [3];
  logic               o_upd_r;

  mwo_pkg::div_req_t div_req;
  mwo_pkg::div_rsp_t div_rsp;

  logic [95:0]   ram_rdata;
  logic [SW-1:0] ram_raddr;
  logic          ram_we;

  logic [31:0]          dt;
  logic [LW-1:0]        len;
  logic [LW-1:0]        slot_ext;
  logic [LW-1:0]        s_eff;
  logic [LW-1:0]        s_next;
  logic signed [65:0]   tr_adj;
  logic signed [31:0]   cur;
  logic signed [34:0]   d_ext [4];
  logic signed [34:0]   sum_vx, sum_vy, sum_w;
  logic signed [34:0]   vx_q, vy_q;
  logic [18:0]          den_w;
  logic signed [31:0]   old_v [3];
  logic                 full;

  mwo_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  mwo_ram #(.WIDTH(96), .DEPTH(WINDOW_DEPTH), .AW(SW)) u_win (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata({v_r[2], v_r[1], v_r[0]}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // elapsed time and effective window length
  assign dt  = now_r - last_r;
  assign len = (wlen_r == 6'd0) ? LW'(1) :
               (32'(wlen_r) > 32'(WINDOW_DEPTH)) ? LW'(WINDOW_DEPTH) : LW'(wlen_r);

  // slot handling
  assign slot_ext  = LW'(slot_r);
  assign s_eff     = (slot_ext >= len) ? LW'(0) : slot_ext;
  assign s_next    = ((slot_ext + LW'(1)) >= len) ? LW'(0) : (slot_ext + LW'(1));
  assign ram_raddr = s_eff[SW-1:0];
  assign ram_we    = (state_r == S_RW);
  assign full      = (fill_r == len);
  assign old_v[0]  = ram_rdata[31:0];
  assign old_v[1]  = ram_rdata[63:32];
  assign old_v[2]  = ram_rdata[95:64];

  // travel: product over 65536, toward zero
  assign tr_adj = mul_p_r + (mul_p_r[65] ? 66'sd65535 : 66'sd0);
  assign cur    = tr_adj[47:16];

  // partial product placement and the reciprocal quotient with its sign
  assign pp_sh  = {({1'b0, pp_r[0]} + {1'b0, pp_r[1]}), 5'd0};
  assign pp_ext = {64'd0, mul_p_r[63:0]} << pp_sh;
  assign rq     = racc_r[127:83];
  assign rquo   = rneg_r ? -$signed({19'd0, rq}) : $signed({19'd0, rq});

  // closed-form solution of the wheel differences
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_ext[i] = 35'(d_r[i]);
    end
    sum_vx = d_ext[0] + d_ext[1] + d_ext[2] + d_ext[3];
    sum_vy = d_ext[1] + d_ext[2] - d_ext[0] - d_ext[3];
    sum_w  = d_ext[2] + d_ext[3] - d_ext[0] - d_ext[1];
    vx_q   = (sum_vx + (sum_vx[34] ? 35'sd3 : 35'sd0)) >>> 2;
    vy_q   = (sum_vy + (sum_vy[34] ? 35'sd3 : 35'sd0)) >>> 2;
    den_w  = (19'(base_r) + 19'(sep_r)) << 1;
  end

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = 64'sd0;
    div_req.den   = 32'd0;
    unique case (state_r)
      S_WS: begin
        div_req.start = (den_w != 19'd0);
        div_req.num   = 64'(sum_w) <<< 16;
        div_req.den   = 32'(den_w);
      end
      S_VD: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p_r[63:0];
        div_req.den   = dt;
      end
      S_MD: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(sum_r[idx_r]);
        div_req.den   = 32'(fill_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a_r * mul_b_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      sep_r       <= 17'd0;
      base_r      <= 17'd0;
      wlen_r      <= mwo_pkg::WLEN_RESET;
      last_r      <= 32'd0;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        rad_r[i]  <= 16'd0;
        trav_r[i] <= 32'sd0;
      end
      for (int i = 0; i < 3; i++) begin
        pose_r[i] <= 32'sd0;
        sum_r[i]  <= '0;
        spd_r[i]  <= 32'sd0;
      end
    end else begin
      // drop the result beat once taken, unless a new one loads now
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ang_r[0] <= in_angle_left_front;
            ang_r[1] <= in_angle_left_rear;
            ang_r[2] <= in_angle_right_front;
            ang_r[3] <= in_angle_right_rear;
            cmd_r[0] <= in_command_vx;
            cmd_r[1] <= in_command_vy;
            cmd_r[2] <= in_command_w;
            now_r    <= in_time_us;
            idx_r    <= 2'd0;
            upd_r    <= 1'b0;
            unique case (in_kind)
              mwo_pkg::KIND_WHEEL: state_r <= S_TM;
              mwo_pkg::KIND_OPEN:  state_r <= S_OM;
              mwo_pkg::KIND_START: begin
                last_r <= in_time_us;
                slot_r <= '0;
                fill_r <= '0;
                for (int i = 0; i < 3; i++) begin
                  sum_r[i] <= '0;
                end
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end

        // wheel travel, one wheel per pass
        S_TM: begin
          mul_a_r <= 33'(ang_r[idx_r]);
          mul_b_r <= $signed({17'd0, rad_r[idx_r]});
          state_r <= S_TW;
        end
        S_TW: state_r <= S_TU;
        S_TU: begin
          d_r[idx_r]    <= 33'(cur) - 33'(trav_r[idx_r]);
          trav_r[idx_r] <= cur;
          if (idx_r == 2'd3) begin
            state_r <= S_WS;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_TM;
          end
        end

        // displacement
        S_WS: begin
          disp_r[0] <= mwo_pkg::sat32(64'(vx_q));
          disp_r[1] <= mwo_pkg::sat32(64'(vy_q));
          if (den_w == 19'd0) begin
            disp_r[2] <= 32'sd0;
            state_r   <= S_POSE;
          end else begin
            state_r <= S_WD;
          end
        end
        S_WD: begin
          if (div_rsp.done) begin
            disp_r[2] <= mwo_pkg::sat32(div_rsp.quo);
            state_r   <= S_POSE;
          end
        end
        S_POSE: begin
          for (int i = 0; i < 3; i++) begin
            pose_r[i] <= pose_r[i] + disp_r[i];
          end
          idx_r <= 2'd0;
          if (dt >= mwo_pkg::MIN_DT) begin
            state_r <= S_VM;
          end else begin
            state_r <= S_OUT;
          end
        end

        // window entries: displacement over time
        S_VM: begin
          mul_a_r <= 33'(disp_r[idx_r]);
          mul_b_r <= $signed({1'b0, mwo_pkg::US_PER_S});
          state_r <= S_VW;
        end
        S_VW: state_r <= S_VD;
        S_VD: state_r <= S_VQ;
        S_VQ: begin
          if (div_rsp.done) begin
            v_r[idx_r] <= mwo_pkg::sat32(div_rsp.quo);
            if (idx_r == 2'd2) begin
              state_r <= S_RD;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_VM;
            end
          end
        end

        // read the oldest entry, then replace it
        S_RD: begin
          last_r  <= now_r;
          slot_r  <= s_eff[SW-1:0];
          fill_r  <= (fill_r > len) ? len : fill_r;
          state_r <= S_RW;
        end
        S_RW: begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] - (full ? SUMW'(old_v[i]) : SUMW'(0)) + SUMW'(v_r[i]);
          end
          if (!full) begin
            fill_r <= fill_r + LW'(1);
          end
          slot_r  <= s_next[SW-1:0];
          idx_r   <= 2'd0;
          state_r <= S_MD;
        end

        // window means
        S_MD: state_r <= S_MQ;
        S_MQ: begin
          if (div_rsp.done) begin
            spd_r[idx_r] <= mwo_pkg::sat32(div_rsp.quo);
            if (idx_r == 2'd2) begin
              upd_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_MD;
            end
          end
        end

        // open loop: command times interval
        S_OM: begin
          mul_a_r <= 33'(cmd_r[idx_r]);
          mul_b_r <= $signed({1'b0, dt});
          state_r <= S_OW;
        end
        S_OW: state_r <= S_OD;
        S_OD: begin
          rneg_r  <= mul_p_r[65];
          rx_r    <= mul_p_r[65] ? 64'(-mul_p_r) : mul_p_r[63:0];
          racc_r  <= '0;
          pp_r    <= 2'd0;
          state_r <= S_OR;
        end

        // magnitude times the reciprocal of 1e6, one 32x32 partial per pass
        S_OR: begin
          mul_a_r <= {1'b0, (pp_r[1] ? rx_r[63:32] : rx_r[31:0])};
          mul_b_r <= {1'b0, (pp_r[0] ? mwo_pkg::US_RECIP[63:32] : mwo_pkg::US_RECIP[31:0])};
          state_r <= S_ORW;
        end
        S_ORW: state_r <= S_ORA;
        S_ORA: begin
          racc_r <= racc_r + pp_ext;
          if (pp_r == 2'd3) begin
            state_r <= S_OQ;
          end else begin
            pp_r    <= pp_r + 2'd1;
            state_r <= S_OR;
          end
        end
        S_OQ: begin
          pose_r[idx_r] <= pose_r[idx_r] + mwo_pkg::sat32(rquo);
          spd_r[idx_r]  <= cmd_r[idx_r];
          if (idx_r == 2'd2) begin
            last_r  <= now_r;
            upd_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_OM;
          end
        end

        // load the result beat
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              o_pose_r[i] <= pose_r[i];
              o_spd_r[i]  <= spd_r[i];
            end
            o_upd_r <= upd_r;
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // configuration writes, taken only while idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mwo_pkg::REG_SEP:  sep_r    <= cfg_data;
          mwo_pkg::REG_BASE: base_r   <= cfg_data;
          mwo_pkg::REG_RLF:  rad_r[0] <= cfg_data[15:0];
          mwo_pkg::REG_RLR:  rad_r[1] <= cfg_data[15:0];
          mwo_pkg::REG_RRF:  rad_r[2] <= cfg_data[15:0];
          mwo_pkg::REG_RRR:  rad_r[3] <= cfg_data[15:0];
          mwo_pkg::REG_WLEN: begin
            wlen_r <= cfg_data[5:0];
            slot_r <= '0;
            fill_r <= '0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = (state_r == S_IDLE) && !in_valid;
  assign out_valid        = out_valid_r;
  assign out_pose_x       = o_pose_r[0];
  assign out_pose_y       = o_pose_r[1];
  assign out_pose_heading = o_pose_r[2];
  assign out_speed_x      = o_spd_r[0];
  assign out_speed_y      = o_spd_r[1];
  assign out_speed_w      = o_spd_r[2];
  assign out_updated      = o_upd_r;

endmodule
`default_nettype wire
